// ----- hdl/timed_event_priority_queue_macros.svh -----
// ---------------------------------------------------------------------------
// timed event priority queue assertion macros
// shared property forms for the queue's concurrent checks
// ---------------------------------------------------------------------------
`ifndef TIMED_EVENT_PRIORITY_QUEUE_MACROS_SVH
`define TIMED_EVENT_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define TEPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tepq check failed");

// next-cycle implication
`define TEPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tepq check failed");

`endif

// ----- hdl/tepq_pkg.sv -----
// ---------------------------------------------------------------------------
// tepq_pkg
// types, codes and constants of the timed event priority queue
// ---------------------------------------------------------------------------
package tepq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int HANDLE_COUNT    = 16;
	localparam int HANDLE_W        = 4;
	localparam int OCC_W           = 5;

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_EMPTY     = 2'd2;
	localparam logic [1:0] STAT_NO_HANDLE = 2'd3;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [31:0]         end_time;
		logic [7:0]          actor_id;
		logic [7:0]          activity_id;
		logic [15:0]         place_code;
		logic [HANDLE_W-1:0] target_handle;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] handle;
		logic [31:0]         out_time;
		logic [7:0]          out_actor;
		logic [7:0]          out_activity;
		logic [15:0]         out_place;
		logic [31:0]         earliest_time;
		logic                is_empty;
		logic [OCC_W-1:0]    occupancy;
	} rsp_t;

	// one queue slot
	typedef struct packed {
		logic [31:0]         ev_time;
		logic [7:0]          actor;
		logic [7:0]          activity;
		logic [15:0]         place;
		logic [HANDLE_W-1:0] hnd;
	} entry_t;

	// pending result fields
	typedef struct packed {
		logic [1:0] status;
		entry_t     ent;
	} res_t;

	// handle map commands from the sequencer
	typedef struct packed {
		logic                alloc;
		logic                free_en;
		logic [HANDLE_W-1:0] free_hnd;
	} hnd_cmd_t;

	// handle map status to the sequencer
	typedef struct packed {
		logic                any_free;
		logic [HANDLE_W-1:0] low_free;
	} hnd_stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_SCAN,
		S_INS_PUT,
		S_REM_SCAN,
		S_REPLY
	} state_t;

endpackage

// ----- hdl/tepq_store.sv -----
// ---------------------------------------------------------------------------
// tepq_store
// slot memory: one write port, one read port with registered data
// ---------------------------------------------------------------------------
module tepq_store #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  tepq_pkg::entry_t           wr_data,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output tepq_pkg::entry_t           rd_data
);

	tepq_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- hdl/tepq_handles.sv -----
// ---------------------------------------------------------------------------
// tepq_handles
// handle-in-use map with lowest-free-handle encoder
// ---------------------------------------------------------------------------
module tepq_handles (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tepq_pkg::hnd_cmd_t                    cmd,
	output tepq_pkg::hnd_stat_t                   stat,
	output logic [tepq_pkg::HANDLE_COUNT-1:0]     in_use
);

	logic [tepq_pkg::HANDLE_COUNT-1:0] map_q;

	assign in_use = map_q;

	// scan from the top so the lowest clear bit wins
	always_comb begin
		stat = '0;
		for (int i = tepq_pkg::HANDLE_COUNT - 1; i >= 0; i--) begin
			if (!map_q[i]) begin
				stat.any_free = 1'b1;
				stat.low_free = tepq_pkg::HANDLE_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else begin
			if (cmd.alloc) begin
				map_q[stat.low_free] <= 1'b1;
			end
			if (cmd.free_en) begin
				map_q[cmd.free_hnd] <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/timed_event_priority_queue.sv -----
// ---------------------------------------------------------------------------
// timed_event_priority_queue
// bounded event queue sorted by end time, with insert, pop and remove
// ---------------------------------------------------------------------------
// A request beat is taken on a clock edge where start is high and busy is
// low; busy then stays high until the single result beat has been shown.
// The result sits on rsp for exactly one cycle with rsp_valid high and
// cannot be held off, so the receiver must take it in that cycle. Slots live
// in a memory with one write port and one registered read port that a small
// sequencer walks one entry per cycle with one time comparator: an insert
// scans from the tail toward the head, moving later entries back as it goes;
// a pop or remove scans from the head and closes the gap behind the removed
// entry. Events with equal times leave in arrival order, inserts take the
// lowest free handle, and every result also carries the head time, an empty
// flag and the occupancy after the request.
// ---------------------------------------------------------------------------
`include "timed_event_priority_queue_macros.svh"

module timed_event_priority_queue #(
	parameter int QUEUE_DEPTH = tepq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  tepq_pkg::req_t req,
	output logic           rsp_valid,
	output tepq_pkg::rsp_t rsp
);

	// only sixteen handles exist, so the usable depth is capped there
	localparam int CAP   = (QUEUE_DEPTH < tepq_pkg::HANDLE_COUNT) ?
		QUEUE_DEPTH : tepq_pkg::HANDLE_COUNT;
	localparam int IDX_W = $clog2(CAP);
	localparam int CNT_W = $clog2(CAP + 1);

	tepq_pkg::state_t    state_q, state_d;
	tepq_pkg::req_t      req_q;
	tepq_pkg::res_t      res_q, res_d;
	logic [IDX_W-1:0]    idx_q, idx_d;
	logic                found_q, found_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [31:0]         head_q;

	// memory port
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	tepq_pkg::entry_t    wr_data;
	logic [IDX_W-1:0]    rd_addr;
	tepq_pkg::entry_t    rd_q;

	// handle map
	tepq_pkg::hnd_cmd_t  hcmd;
	tepq_pkg::hnd_stat_t hstat;
	logic [tepq_pkg::HANDLE_COUNT-1:0] hmap;

	tepq_pkg::entry_t    new_entry;
	logic [CNT_W-1:0]    cnt_m1;
	logic [IDX_W-1:0]    last_idx;
	logic                is_last;
	logic                hit;

	tepq_store #(
		.DEPTH (CAP)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_q)
	);

	tepq_handles u_handles (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (hcmd),
		.stat   (hstat),
		.in_use (hmap)
	);

	// entry built from the held request, tagged with the lowest free handle
	always_comb begin
		new_entry.ev_time  = req_q.end_time;
		new_entry.actor    = req_q.actor_id;
		new_entry.activity = req_q.activity_id;
		new_entry.place    = req_q.place_code;
		new_entry.hnd      = hstat.low_free;
	end

	assign cnt_m1   = count_q - CNT_W'(1);
	assign last_idx = cnt_m1[IDX_W-1:0];
	assign is_last  = (idx_q == last_idx);
	// a pop always takes the head, a remove matches on the handle
	assign hit      = (req_q.req_type == tepq_pkg::REQ_POP) ? 1'b1 :
		(rd_q.hnd == req_q.target_handle);

	// sequencer: next state, memory port and handle map control
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		found_d = found_q;
		res_d   = res_q;
		count_d = count_q;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = new_entry;
		rd_addr = idx_q;
		hcmd    = '0;
		case (state_q)
			tepq_pkg::S_IDLE: begin
				if (start) begin
					state_d = tepq_pkg::S_DISPATCH;
				end
			end
			tepq_pkg::S_DISPATCH: begin
				res_d   = '0;
				state_d = tepq_pkg::S_REPLY;
				case (req_q.req_type)
					tepq_pkg::REQ_INSERT: begin
						if (count_q >= CNT_W'(CAP) || !hstat.any_free) begin
							res_d.status = tepq_pkg::STAT_FULL;
						end else if (count_q == '0) begin
							// empty queue: new entry goes straight to the head
							wr_en          = 1'b1;
							wr_addr        = '0;
							count_d        = count_q + CNT_W'(1);
							hcmd.alloc     = 1'b1;
							res_d.ent.hnd  = hstat.low_free;
						end else begin
							rd_addr = last_idx;
							idx_d   = last_idx;
							state_d = tepq_pkg::S_INS_SCAN;
						end
					end
					tepq_pkg::REQ_POP, tepq_pkg::REQ_REMOVE: begin
						if (count_q == '0) begin
							res_d.status = tepq_pkg::STAT_EMPTY;
						end else begin
							rd_addr = '0;
							idx_d   = '0;
							found_d = 1'b0;
							state_d = tepq_pkg::S_REM_SCAN;
						end
					end
					default: begin
						// unused code: summary only
					end
				endcase
			end
			tepq_pkg::S_INS_SCAN: begin
				wr_en   = 1'b1;
				wr_addr = idx_q + IDX_W'(1);
				if (rd_q.ev_time > req_q.end_time) begin
					// later entry moves back one slot
					wr_data = rd_q;
					if (idx_q == '0) begin
						state_d = tepq_pkg::S_INS_PUT;
					end else begin
						idx_d   = idx_q - IDX_W'(1);
						rd_addr = idx_q - IDX_W'(1);
					end
				end else begin
					// behind every entry with time less or equal
					count_d       = count_q + CNT_W'(1);
					hcmd.alloc    = 1'b1;
					res_d.ent.hnd = hstat.low_free;
					state_d       = tepq_pkg::S_REPLY;
				end
			end
			tepq_pkg::S_INS_PUT: begin
				wr_en         = 1'b1;
				wr_addr       = '0;
				count_d       = count_q + CNT_W'(1);
				hcmd.alloc    = 1'b1;
				res_d.ent.hnd = hstat.low_free;
				state_d       = tepq_pkg::S_REPLY;
			end
			tepq_pkg::S_REM_SCAN: begin
				if (found_q) begin
					// close the gap behind the removed entry
					wr_en   = 1'b1;
					wr_addr = idx_q - IDX_W'(1);
					wr_data = rd_q;
				end else if (hit) begin
					found_d   = 1'b1;
					res_d.ent = rd_q;
				end
				if (is_last) begin
					if (found_q || hit) begin
						count_d       = cnt_m1;
						hcmd.free_en  = 1'b1;
						hcmd.free_hnd = found_q ? res_q.ent.hnd : rd_q.hnd;
					end else begin
						res_d.status = tepq_pkg::STAT_NO_HANDLE;
					end
					state_d = tepq_pkg::S_REPLY;
				end else begin
					idx_d   = idx_q + IDX_W'(1);
					rd_addr = idx_q + IDX_W'(1);
				end
			end
			tepq_pkg::S_REPLY: begin
				state_d = tepq_pkg::S_IDLE;
			end
			default: begin
				state_d = tepq_pkg::S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tepq_pkg::S_IDLE;
			count_q <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			found_q <= found_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req;
		end
		res_q <= res_d;
		idx_q <= idx_d;
		// shadow of slot zero's time for the head report
		if (wr_en && wr_addr == '0) begin
			head_q <= wr_data.ev_time;
		end
	end

	assign busy      = (state_q != tepq_pkg::S_IDLE);
	assign rsp_valid = (state_q == tepq_pkg::S_REPLY);

	// result beat: removed entry fields plus queue summary
	always_comb begin
		rsp.status        = res_q.status;
		rsp.handle        = res_q.ent.hnd;
		rsp.out_time      = res_q.ent.ev_time;
		rsp.out_actor     = res_q.ent.actor;
		rsp.out_activity  = res_q.ent.activity;
		rsp.out_place     = res_q.ent.place;
		rsp.earliest_time = (count_q != '0) ? head_q : 32'd0;
		rsp.is_empty      = (count_q == '0);
		rsp.occupancy     = tepq_pkg::OCC_W'(count_q);
	end

	// occupancy never passes the capacity
	`TEPQ_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(CAP))
	// every held event owns exactly one handle
	`TEPQ_ASSERT_NOW(a_count_handles, clk, arst_n, 1'b1, $countones(hmap) == int'(count_q))
	// the result strobe lasts a single cycle
	`TEPQ_ASSERT_NEXT(a_strobe_single, clk, arst_n, rsp_valid, !rsp_valid)
	// an accepted request always makes the block busy
	`TEPQ_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)

endmodule
